### rtl/core/i2cmrs_pkg.sv
// Package for the I2C master register read sequencer.
// Holds item and state types, phase and command codes, and TWI status codes.
// No dependencies.
package i2cmrs_pkg;

    typedef enum logic [0:0] {
        OP_BEGIN    = 1'b0,
        OP_COMPLETE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_SLA_W   = 3'd2,
        PH_REG     = 3'd3,
        PH_RESTART = 3'd4,
        PH_SLA_R   = 3'd5,
        PH_DATA    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_TX      = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4
    } t_bus_cmd;

    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_SLA_W    = 8'h18;
    localparam logic [7:0] ST_REG      = 8'h28;
    localparam logic [7:0] ST_SLA_R    = 8'h40;
    localparam logic [7:0] ST_DATA_ACK = 8'h50;
    localparam logic [7:0] ST_DATA_NAK = 8'h58;
    localparam logic [7:0] ST_MASK     = 8'hF8;

    typedef struct packed {
        logic [0:0] opcode;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] read_length;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] transmit_byte;
        logic [0:0] data_valid;
        logic [7:0] data_byte;
        logic [0:0] done_res;
        logic [0:0] error;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] bytes_left;
        logic [6:0] target_address;
        logic [7:0] target_register;
    } t_seq_state;

endpackage

### rtl/core/i2cmrs_step.sv
// Next-state and result logic of the I2C register read sequencer.
// Depends on i2cmrs_pkg for item, state and code types.
module i2cmrs_step (
    input  i2cmrs_pkg::t_in_item   i_item,
    input  i2cmrs_pkg::t_seq_state i_state,
    output i2cmrs_pkg::t_seq_state o_state,
    output i2cmrs_pkg::t_out_item  o_result
);

    logic [7:0]           status;
    logic                 fail;
    logic                 last_byte;
    i2cmrs_pkg::t_bus_cmd rx_cmd;

    assign status    = i_item.bus_status & i2cmrs_pkg::ST_MASK;
    assign last_byte = (i_state.bytes_left == 8'd1);
    assign rx_cmd    = last_byte ? i2cmrs_pkg::CMD_RX_NACK : i2cmrs_pkg::CMD_RX_ACK;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        fail     = 1'b0;
        if (i2cmrs_pkg::t_opcode'(i_item.opcode) == i2cmrs_pkg::OP_BEGIN) begin
            // restart from scratch, whatever was running
            o_state.target_address  = i_item.slave_address;
            o_state.target_register = i_item.register_address;
            o_state.bytes_left      = i_item.read_length;
            o_state.phase           = i2cmrs_pkg::PH_START;
            o_result.bus_command    = i2cmrs_pkg::CMD_START;
        end else begin
            case (i_state.phase)
                i2cmrs_pkg::PH_START: begin
                    if (status == i2cmrs_pkg::ST_START) begin
                        o_result.bus_command   = i2cmrs_pkg::CMD_TX;
                        o_result.transmit_byte = {i_state.target_address, 1'b0};
                        o_state.phase          = i2cmrs_pkg::PH_SLA_W;
                    end else begin
                        fail = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_SLA_W: begin
                    if (status == i2cmrs_pkg::ST_SLA_W) begin
                        o_result.bus_command   = i2cmrs_pkg::CMD_TX;
                        o_result.transmit_byte = i_state.target_register;
                        o_state.phase          = i2cmrs_pkg::PH_REG;
                    end else begin
                        fail = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_REG: begin
                    if (status == i2cmrs_pkg::ST_REG) begin
                        o_result.bus_command = i2cmrs_pkg::CMD_START;
                        o_state.phase        = i2cmrs_pkg::PH_RESTART;
                    end else begin
                        fail = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_RESTART: begin
                    // repeated start status is taken as is
                    o_result.bus_command   = i2cmrs_pkg::CMD_TX;
                    o_result.transmit_byte = {i_state.target_address, 1'b1};
                    o_state.phase          = i2cmrs_pkg::PH_SLA_R;
                end
                i2cmrs_pkg::PH_SLA_R: begin
                    if (status != i2cmrs_pkg::ST_SLA_R) begin
                        fail = 1'b1;
                    end else if (i_state.bytes_left == 8'd0) begin
                        o_result.done_res = 1'b1;
                        o_state.phase     = i2cmrs_pkg::PH_IDLE;
                    end else begin
                        o_result.bus_command = rx_cmd;
                        o_state.phase        = i2cmrs_pkg::PH_DATA;
                    end
                end
                i2cmrs_pkg::PH_DATA: begin
                    if ((i_state.bytes_left > 8'd1 && status == i2cmrs_pkg::ST_DATA_ACK) ||
                        (last_byte && status == i2cmrs_pkg::ST_DATA_NAK)) begin
                        o_result.data_valid = 1'b1;
                        o_result.data_byte  = i_item.received_byte;
                        o_state.bytes_left  = i_state.bytes_left - 8'd1;
                        if (last_byte) begin
                            o_result.done_res = 1'b1;
                            o_state.phase     = i2cmrs_pkg::PH_IDLE;
                        end else begin
                            // two or more left before this beat: next is ack unless one remains
                            o_result.bus_command = (i_state.bytes_left == 8'd2) ?
                                i2cmrs_pkg::CMD_RX_NACK : i2cmrs_pkg::CMD_RX_ACK;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: begin
                    o_state.phase = i2cmrs_pkg::PH_IDLE;
                end
            endcase
            if (fail) begin
                o_result.error = 1'b1;
                o_state.phase  = i2cmrs_pkg::PH_IDLE;
            end
        end
    end

endmodule

### rtl/core/i2c_master_register_read_sequencer.sv
// Top level of the I2C master register read sequencer.
// Depends on i2cmrs_pkg and i2cmrs_step.
//
// Drives a byte-level I2C bus engine through one combined register read:
// START, address+W, register byte, repeated START, address+R, then the
// requested number of receives, all acknowledged but the last. Every input
// beat (a begin request or an engine completion) yields exactly one output
// beat carrying the next bus command and, on a receive, the data byte; a
// done flag marks the end of a read and an error flag an aborted one (no
// STOP is issued). A begin beat while a read is running drops that read and
// starts over. The step logic sits between the sequencer state and a single
// output register, so a new beat is taken in every cycle in which the output
// register is empty or being drained, and its result beat appears in the
// cycle after it is accepted.
module i2c_master_register_read_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cmrs_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cmrs_pkg::t_out_item o_out_data
);

    i2cmrs_pkg::t_seq_state r_state;
    i2cmrs_pkg::t_seq_state n_state;
    i2cmrs_pkg::t_out_item  r_out;
    i2cmrs_pkg::t_out_item  n_out;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   in_accept;

    // Hold the input only while a result waits and the sink stalls.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    i2cmrs_step u_step (
        .i_item   (i_in_data),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Drop the output beat once taken; a fresh accept refills it the same edge.
    always_comb begin
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Sequencer state: advance only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= i2cmrs_pkg::PH_IDLE;
            r_state.bytes_left      <= '0;
            r_state.target_address  <= '0;
            r_state.target_register <= '0;
            r_out_valid             <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A finished or aborted read never carries both flags.
    a_done_xor_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.done_res && o_out_data.error))
        else $error("done and error set together");

    // A returned byte comes only with a receive command or the end of the read.
    a_data_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.data_valid) |->
            (o_out_data.bus_command == i2cmrs_pkg::CMD_NONE ||
             o_out_data.bus_command == i2cmrs_pkg::CMD_RX_ACK ||
             o_out_data.bus_command == i2cmrs_pkg::CMD_RX_NACK))
        else $error("data byte with a non-receive command");

    // A begin beat always lands the sequencer in the start phase.
    a_begin_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.opcode == i2cmrs_pkg::OP_BEGIN) |=>
            (r_state.phase == i2cmrs_pkg::PH_START && o_out_valid &&
             o_out_data.bus_command == i2cmrs_pkg::CMD_START))
        else $error("begin did not issue start");

    // An error or done result leaves the sequencer idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_out.error || n_out.done_res)) |=>
            (r_state.phase == i2cmrs_pkg::PH_IDLE))
        else $error("sequencer not idle after end of read");

endmodule

### verif/i2c_master_register_read_sequencer_tb.sv
// Self-checking testbench for the I2C master register read sequencer.
// Depends on i2cmrs_pkg and i2c_master_register_read_sequencer; a clocked driver,
// monitor and stall generator exercise it against an in-bench sequencer predictor.
module i2c_master_register_read_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Abort when no beat moves on either side for WATCHDOG_CYCLES; the longest legal
    // quiet stretch is the receiver hold-off (HOLD_OFF_CYCLES) plus a few stall draws.
    localparam int unsigned WATCHDOG_CYCLES = 5000;
    localparam int unsigned RANDOM_BEATS    = 850;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned HOLD_OFF_AFTER  = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    i2cmrs_pkg::t_in_item  i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    i2cmrs_pkg::t_out_item o_out_data;

    i2c_master_register_read_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Request beats waiting to be driven, and result beats still owed by the block.
    i2cmrs_pkg::t_in_item  pending_beats[$];
    i2cmrs_pkg::t_out_item expected_results[$];

    int unsigned beats_offered = 0;   // written on the falling edge by the driver
    int unsigned beats_taken = 0;     // written on the rising edge by the monitor
    int unsigned results_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned planned_beats = 0;

    // Predicted sequencer state; reset happens once, so start from the reset values.
    i2cmrs_pkg::t_phase seq_phase = i2cmrs_pkg::PH_IDLE;
    logic [7:0]         bytes_pending = '0;
    logic [6:0]         seq_addr = '0;
    logic [7:0]         seq_reg = '0;

    // ------------------------------------------------------------------
    // Predictor: advance the sequencer by one beat and return its result.
    // ------------------------------------------------------------------
    function automatic i2cmrs_pkg::t_out_item predict_read_step(i2cmrs_pkg::t_in_item beat);
        i2cmrs_pkg::t_out_item r;
        logic [7:0]            status;
        logic                  failed;
        r = '0;
        status = beat.bus_status & i2cmrs_pkg::ST_MASK;
        failed = 1'b0;
        if (beat.opcode == i2cmrs_pkg::OP_BEGIN) begin
            // A begin always wins, even over a read that is still running.
            seq_addr = beat.slave_address;
            seq_reg = beat.register_address;
            bytes_pending = beat.read_length;
            seq_phase = i2cmrs_pkg::PH_START;
            r.bus_command = i2cmrs_pkg::CMD_START;
        end else begin
            case (seq_phase)
                i2cmrs_pkg::PH_START: begin
                    if (status == i2cmrs_pkg::ST_START) begin
                        r.bus_command = i2cmrs_pkg::CMD_TX;
                        r.transmit_byte = {seq_addr, 1'b0};
                        seq_phase = i2cmrs_pkg::PH_SLA_W;
                    end else begin
                        failed = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_SLA_W: begin
                    if (status == i2cmrs_pkg::ST_SLA_W) begin
                        r.bus_command = i2cmrs_pkg::CMD_TX;
                        r.transmit_byte = seq_reg;
                        seq_phase = i2cmrs_pkg::PH_REG;
                    end else begin
                        failed = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_REG: begin
                    if (status == i2cmrs_pkg::ST_REG) begin
                        r.bus_command = i2cmrs_pkg::CMD_START;
                        seq_phase = i2cmrs_pkg::PH_RESTART;
                    end else begin
                        failed = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_RESTART: begin
                    // Whatever the engine reports after the repeated start is taken.
                    r.bus_command = i2cmrs_pkg::CMD_TX;
                    r.transmit_byte = {seq_addr, 1'b1};
                    seq_phase = i2cmrs_pkg::PH_SLA_R;
                end
                i2cmrs_pkg::PH_SLA_R: begin
                    if (status != i2cmrs_pkg::ST_SLA_R) begin
                        failed = 1'b1;
                    end else if (bytes_pending == 8'd0) begin
                        r.done_res = 1'b1;
                        seq_phase = i2cmrs_pkg::PH_IDLE;
                    end else begin
                        r.bus_command = (bytes_pending == 8'd1) ?
                            i2cmrs_pkg::CMD_RX_NACK : i2cmrs_pkg::CMD_RX_ACK;
                        seq_phase = i2cmrs_pkg::PH_DATA;
                    end
                end
                i2cmrs_pkg::PH_DATA: begin
                    if ((bytes_pending > 8'd1 && status == i2cmrs_pkg::ST_DATA_ACK) ||
                        (bytes_pending == 8'd1 && status == i2cmrs_pkg::ST_DATA_NAK)) begin
                        r.data_valid = 1'b1;
                        r.data_byte = beat.received_byte;
                        bytes_pending = bytes_pending - 8'd1;
                        if (bytes_pending == 8'd0) begin
                            r.done_res = 1'b1;
                            seq_phase = i2cmrs_pkg::PH_IDLE;
                        end else begin
                            r.bus_command = (bytes_pending == 8'd1) ?
                                i2cmrs_pkg::CMD_RX_NACK : i2cmrs_pkg::CMD_RX_ACK;
                        end
                    end else begin
                        failed = 1'b1;
                    end
                end
                default: seq_phase = i2cmrs_pkg::PH_IDLE;   // idle: completions are ignored
            endcase
            if (failed) begin
                // Abort without a stop; the requester sees only the error flag.
                r.error = 1'b1;
                seq_phase = i2cmrs_pkg::PH_IDLE;
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic i2cmrs_pkg::t_in_item random_beat();
        i2cmrs_pkg::t_in_item b;
        b.opcode = 1'($urandom);
        b.slave_address = 7'($urandom);
        b.register_address = 8'($urandom);
        b.read_length = 8'($urandom);
        b.bus_status = 8'($urandom);
        b.received_byte = 8'($urandom);
        return b;
    endfunction

    task automatic push_beat(input i2cmrs_pkg::t_opcode op, input logic [6:0] addr,
                             input logic [7:0] regb, input logic [7:0] len,
                             input logic [7:0] status, input logic [7:0] rx);
        i2cmrs_pkg::t_in_item b;
        b.opcode = op;
        b.slave_address = addr;
        b.register_address = regb;
        b.read_length = len;
        b.bus_status = status;
        b.received_byte = rx;
        pending_beats.push_back(b);
    endtask

    // Queue one register read with random content: a begin, then the engine's
    // completions in order. Now and then break it at a random step with a bad
    // status, a swapped ack/nack class, a begin on top, or by cutting it short.
    task automatic queue_read(input bit allow_faults);
        i2cmrs_pkg::t_in_item beat;
        logic [7:0]           len;
        logic [7:0]           good;
        int unsigned          steps;
        int unsigned          fault_at;
        int unsigned          kind;
        int unsigned          k;
        len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 5));
        steps = 5 + len;
        fault_at = (allow_faults && $urandom_range(0, 3) == 0) ?
                   $urandom_range(0, steps - 1) : steps;
        beat = random_beat();
        beat.opcode = i2cmrs_pkg::OP_BEGIN;
        beat.read_length = len;
        pending_beats.push_back(beat);
        planned_beats++;
        for (k = 0; k < steps; k++) begin
            beat = random_beat();
            beat.opcode = i2cmrs_pkg::OP_COMPLETE;
            case (k)
                0:       good = i2cmrs_pkg::ST_START;
                1:       good = i2cmrs_pkg::ST_SLA_W;
                2:       good = i2cmrs_pkg::ST_REG;
                3:       good = beat.bus_status;   // repeated start: any status
                4:       good = i2cmrs_pkg::ST_SLA_R;
                default: good = (k == steps - 1) ? i2cmrs_pkg::ST_DATA_NAK
                                                 : i2cmrs_pkg::ST_DATA_ACK;
            endcase
            // Keep the don't-care low bits random.
            beat.bus_status = (good & i2cmrs_pkg::ST_MASK) |
                              (beat.bus_status & ~i2cmrs_pkg::ST_MASK);
            if (k == fault_at) begin
                kind = $urandom_range(0, 3);
                if (kind == 3) break;
                if (kind == 0) beat.bus_status = 8'($urandom);
                else if (kind == 1) beat.bus_status = beat.bus_status ^ 8'h08;
                else beat.opcode = i2cmrs_pkg::OP_BEGIN;
                pending_beats.push_back(beat);
                planned_beats++;
                break;
            end
            pending_beats.push_back(beat);
            planned_beats++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: present one beat at a time, hold it while stalled,
    // then wait out a random gap before the next one.
    // ------------------------------------------------------------------
    int unsigned gap_left = 0;
    bit          send_quiet = 1'b0;

    always @(negedge i_clk) begin : drive_requests
        logic offer;
        offer = i_in_valid;
        if (i_rst_n && beats_taken == beats_offered) begin
            offer = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_beats.size() != 0) begin
                i_in_data <= pending_beats.pop_front();
                beats_offered <= beats_offered + 1;
                offer = 1'b1;
                // Switch now and then into a back-to-back stretch.
                if (beats_offered % 48 == 0) send_quiet = ($urandom_range(0, 3) == 0);
                gap_left = send_quiet ? 0 : $urandom_range(0, 13);
            end
        end
        i_in_valid <= offer;
    end

    // ------------------------------------------------------------------
    // Result stall: draw a wait after every result beat; once, hold off long
    // enough for the output register to fill and back-pressure the input.
    // ------------------------------------------------------------------
    int unsigned results_seen = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          recv_quiet = 1'b0;
    bit          pressure_done = 1'b0;

    always @(negedge i_clk) begin : drive_result_stall
        if (results_taken != results_seen) begin
            results_seen = results_taken;
            if (results_seen % 48 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
            stall_left = recv_quiet ? 0 : $urandom_range(0, 13);
            if (!pressure_done && results_seen >= HOLD_OFF_AFTER) begin
                hold_left = HOLD_OFF_CYCLES;
                pressure_done = 1'b1;
            end
        end
        i_out_stall <= (hold_left != 0) || (stall_left != 0);
        if (hold_left != 0) hold_left--;
        if (stall_left != 0) stall_left--;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted request beat, check every accepted
    // result beat against the oldest prediction, and watch for a hang.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        logic                  req_beat;
        logic                  res_beat;
        i2cmrs_pkg::t_out_item want;
        req_beat = i_rst_n && i_in_valid && !o_in_stall;
        res_beat = i_rst_n && o_out_valid && !i_out_stall;
        // Check the result first: it always stems from an earlier request.
        if (res_beat) begin
            results_taken <= results_taken + 1;
            if (expected_results.size() == 0) begin
                $display({"%0t ns: result with nothing expected, ",
                          "actual cmd %0d tx %0h dv %0b db %0h done %0b err %0b"},
                         $time, o_out_data.bus_command, o_out_data.transmit_byte,
                         o_out_data.data_valid, o_out_data.data_byte,
                         o_out_data.done_res, o_out_data.error);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                report_field("bus_command", 8'(want.bus_command), 8'(o_out_data.bus_command));
                report_field("transmit_byte", want.transmit_byte, o_out_data.transmit_byte);
                report_field("data_valid", 8'(want.data_valid), 8'(o_out_data.data_valid));
                report_field("data_byte", want.data_byte, o_out_data.data_byte);
                report_field("done_res", 8'(want.done_res), 8'(o_out_data.done_res));
                report_field("error", 8'(want.error), 8'(o_out_data.error));
            end
        end
        if (req_beat) begin
            beats_taken <= beats_taken + 1;
            expected_results.push_back(predict_read_step(i_in_data));
        end
        if (req_beat || res_beat) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // Completion while idle: ignored, all-zero result.
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h7F, 8'hFF, 8'hFF, i2cmrs_pkg::ST_START, 8'hFF);

        // Zero-length read at the top address and register; low status bits
        // set on the start acknowledge must be masked off.
        push_beat(i2cmrs_pkg::OP_BEGIN, 7'h7F, 8'hFF, 8'h00, 8'h00, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00,
                  i2cmrs_pkg::ST_START | 8'h07, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_SLA_W, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_REG, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_SLA_R, 8'h00);

        // Single-byte read at address and register zero: straight to a nack
        // receive; the last byte comes back with done.
        push_beat(i2cmrs_pkg::OP_BEGIN, 7'h00, 8'h00, 8'h01, 8'hFF, 8'hFF);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h7F, 8'hFF, 8'hFF, i2cmrs_pkg::ST_START, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h7F, 8'hFF, 8'hFF, i2cmrs_pkg::ST_SLA_W, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h7F, 8'hFF, 8'hFF, i2cmrs_pkg::ST_REG, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h7F, 8'hFF, 8'hFF, i2cmrs_pkg::ST_SLA_R, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00,
                  i2cmrs_pkg::ST_DATA_NAK, 8'hFF);

        // Begin while busy restarts with the new target; then a wrong status
        // after the start aborts with the error flag.
        push_beat(i2cmrs_pkg::OP_BEGIN, 7'h2A, 8'h5A, 8'h02, 8'h00, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_START, 8'h00);
        push_beat(i2cmrs_pkg::OP_BEGIN, 7'h55, 8'hA5, 8'hFF, 8'h00, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_SLA_W, 8'h00);

        // Nack status where an ack is due (two bytes left): error in the data phase.
        push_beat(i2cmrs_pkg::OP_BEGIN, 7'h11, 8'h22, 8'h02, 8'h00, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_START, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_SLA_W, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_REG, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, 8'h55, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00, i2cmrs_pkg::ST_SLA_R, 8'h00);
        push_beat(i2cmrs_pkg::OP_COMPLETE, 7'h00, 8'h00, 8'h00,
                  i2cmrs_pkg::ST_DATA_NAK, 8'hA5);

        // Random part: mostly well-formed reads, a share of them broken, plus
        // unrelated noise beats that do not count toward the total.
        while (planned_beats < RANDOM_BEATS) begin
            if ($urandom_range(0, 7) == 0) pending_beats.push_back(random_beat());
            queue_read(1'b1);
        end

        // Hold reset, then release it away from the rising edge.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every beat accepted and every result checked, then let the
        // output register settle before the final report.
        while (pending_beats.size() != 0 || beats_taken != beats_offered ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/i2cmrs_pkg.sv
rtl/core/i2cmrs_step.sv
rtl/core/i2c_master_register_read_sequencer.sv
verif/i2c_master_register_read_sequencer_tb.sv
